// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MQ_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define MQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/mqsb_pkg.sv -----
// Shared constants, codes and types of the multi-queue shared buffer
`timescale 1ns / 1ps

package mqsb_pkg;

    localparam int SLOTS      = 256;
    localparam int QUEUES     = 8;
    localparam int DATA_WIDTH = 32;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W  = $clog2(SLOTS + 1);
    localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    localparam int OP_W     = 1;
    localparam int QSEL_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = ((QSEL_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + 7) / 8) * 8;

    localparam logic [PTR_W-1:0] NIL = PTR_W'(SLOTS);

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    function automatic logic is_slot(input logic [PTR_W-1:0] p);
        return p < PTR_W'(SLOTS);
    endfunction

endpackage

// ----- hdl/multi_queue_shared_buffer_top.sv -----
// Top level of the multi-queue shared buffer: queues linked through one slot store
`timescale 1ns / 1ps

// Eight FIFO queues share a store of 256 slots. Each input item is an enqueue
// (s_tuser = 0) of a word into the queue named in s_tdata, or a dequeue
// (s_tuser = 1) from it; exactly one result item follows per input item, with
// the status in m_tuser and the dequeued word (or -1 on underflow, 0 after an
// enqueue) in m_tdata. Every item passes through ST_IDLE, where it is accepted
// and the link and data memories are read at the slot chosen by the free-list
// head or the queue head, and then ST_EXEC, which updates the pointers and
// writes the single link-memory port back. A new item is taken in ST_IDLE, after
// the result of the last one is registered, while the output register is free or
// being read. The link memory's reset contents come from per-entry valid bits,
// so no clearing pass is needed after reset.
module multi_queue_shared_buffer_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [2:0] queue_index, [34:3] value, [39:35] zero
    input  logic [mqsb_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] operation
    input  logic [mqsb_pkg::OP_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] read_value
    output logic [mqsb_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [mqsb_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int PTR_W  = mqsb_pkg::PTR_W;
    localparam int SLOT_W = mqsb_pkg::SLOT_W;
    localparam int DW     = mqsb_pkg::DATA_WIDTH;

    // memories
    logic [PTR_W-1:0] link_mem  [mqsb_pkg::SLOTS];
    logic [DW-1:0]    value_mem [mqsb_pkg::SLOTS];
    logic [mqsb_pkg::SLOTS-1:0] link_vld_reg;

    // pointer registers
    logic [PTR_W-1:0] head_reg [mqsb_pkg::QUEUES];
    logic [PTR_W-1:0] tail_reg [mqsb_pkg::QUEUES];
    logic [PTR_W-1:0] free_head_reg, free_head_next;

    mqsb_pkg::state_t state_reg, state_next;

    // item captured at accept
    mqsb_pkg::op_t              op_reg;
    logic [mqsb_pkg::QSEL_W-1:0] q_reg;
    logic [DW-1:0]              data_reg;
    logic [PTR_W-1:0]           rd_addr_reg;
    logic                       rd_vld_reg;
    logic [PTR_W-1:0]           link_q_reg;
    logic [DW-1:0]              value_q_reg;

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [mqsb_pkg::VALUE_W-1:0] m_value_reg, m_value_next;
    mqsb_pkg::status_t            m_status_reg, m_status_next;

    logic                        accept;
    mqsb_pkg::op_t               in_op;
    logic [mqsb_pkg::QSEL_W-1:0] in_q;
    logic                        in_q_ok;
    logic [PTR_W-1:0]            rd_addr;

    logic                  q_ok;
    logic [PTR_W-1:0]      cur_head, cur_tail, link_rd;
    logic                  head_we, tail_we;
    logic [PTR_W-1:0]      head_wval, tail_wval;
    logic                  link_we, value_we;
    logic [SLOT_W-1:0]     link_waddr;
    logic [PTR_W-1:0]      link_wdata;

    assign in_op   = mqsb_pkg::op_t'(s_tuser);
    assign in_q    = s_tdata[mqsb_pkg::QSEL_W-1:0];
    assign in_q_ok = 32'(in_q) < mqsb_pkg::QUEUES;
    assign accept  = s_tvalid && s_tready;

    // read address: queue head for a dequeue, free-list head for an enqueue
    always_comb begin
        if (in_op == mqsb_pkg::OP_DEQUEUE) begin
            rd_addr = in_q_ok ? head_reg[in_q[mqsb_pkg::QIDX_W-1:0]] : mqsb_pkg::NIL;
        end else begin
            rd_addr = free_head_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            link_q_reg  <= link_mem[rd_addr[SLOT_W-1:0]];
            value_q_reg <= value_mem[rd_addr[SLOT_W-1:0]];
            rd_vld_reg  <= link_vld_reg[rd_addr[SLOT_W-1:0]];
            rd_addr_reg <= rd_addr;
            op_reg      <= in_op;
            q_reg       <= in_q;
            data_reg    <= s_tdata[mqsb_pkg::QSEL_W +: DW];
        end
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (value_we) begin
            value_mem[rd_addr_reg[SLOT_W-1:0]] <= data_reg;
        end
    end

    // an unwritten link entry reads as its reset value, slot + 1
    assign link_rd  = rd_vld_reg ? link_q_reg : rd_addr_reg + PTR_W'(1);
    assign q_ok     = 32'(q_reg) < mqsb_pkg::QUEUES;
    assign cur_head = q_ok ? head_reg[q_reg[mqsb_pkg::QIDX_W-1:0]] : mqsb_pkg::NIL;
    assign cur_tail = q_ok ? tail_reg[q_reg[mqsb_pkg::QIDX_W-1:0]] : mqsb_pkg::NIL;

    always_comb begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_value_next   = m_value_reg;
        m_status_next  = m_status_reg;
        head_we        = 1'b0;
        tail_we        = 1'b0;
        head_wval      = mqsb_pkg::NIL;
        tail_wval      = mqsb_pkg::NIL;
        link_we        = 1'b0;
        link_waddr     = rd_addr_reg[SLOT_W-1:0];
        link_wdata     = free_head_reg;
        value_we       = 1'b0;
        s_tready       = 1'b0;
        case (state_reg)
            mqsb_pkg::ST_IDLE: begin
                // take an item only if the output register is free by the next cycle
                s_tready = !m_valid_reg || m_tready;
                if (accept) begin
                    state_next = mqsb_pkg::ST_EXEC;
                end
            end
            mqsb_pkg::ST_EXEC: begin
                state_next   = mqsb_pkg::ST_IDLE;
                m_valid_next = 1'b1;
                if (op_reg == mqsb_pkg::OP_ENQUEUE) begin
                    m_value_next  = '0;
                    m_status_next = mqsb_pkg::STATUS_OVERFLOW;
                    if (q_ok && mqsb_pkg::is_slot(free_head_reg)) begin
                        m_status_next  = mqsb_pkg::STATUS_DONE;
                        free_head_next = link_rd;
                        value_we       = 1'b1;
                        tail_we        = 1'b1;
                        tail_wval      = rd_addr_reg;
                        if (!mqsb_pkg::is_slot(cur_head)) begin
                            head_we   = 1'b1;
                            head_wval = rd_addr_reg;
                        end else if (mqsb_pkg::is_slot(cur_tail)) begin
                            link_we    = 1'b1;
                            link_waddr = cur_tail[SLOT_W-1:0];
                            link_wdata = rd_addr_reg;
                        end
                    end
                end else begin
                    m_value_next  = '1;
                    m_status_next = mqsb_pkg::STATUS_UNDERFLOW;
                    if (q_ok && mqsb_pkg::is_slot(cur_head)) begin
                        m_status_next  = mqsb_pkg::STATUS_DONE;
                        m_value_next   = mqsb_pkg::VALUE_W'(value_q_reg);
                        head_we        = 1'b1;
                        // the tail's link is never consulted: the tail marks the end
                        if (cur_head == cur_tail || !mqsb_pkg::is_slot(link_rd)) begin
                            tail_we = 1'b1;
                        end else begin
                            head_wval = link_rd;
                        end
                        // push the freed slot onto the free list
                        link_we        = 1'b1;
                        link_waddr     = rd_addr_reg[SLOT_W-1:0];
                        link_wdata     = free_head_reg;
                        free_head_next = rd_addr_reg;
                    end
                end
            end
            default: begin
                state_next = mqsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mqsb_pkg::ST_IDLE;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
            link_vld_reg  <= '0;
            for (int i = 0; i < mqsb_pkg::QUEUES; i++) begin
                head_reg[i] <= mqsb_pkg::NIL;
                tail_reg[i] <= mqsb_pkg::NIL;
            end
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
            if (link_we) begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
            if (head_we) begin
                head_reg[q_reg[mqsb_pkg::QIDX_W-1:0]] <= head_wval;
            end
            if (tail_we) begin
                tail_reg[q_reg[mqsb_pkg::QIDX_W-1:0]] <= tail_wval;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = mqsb_pkg::M_TDATA_W'(m_value_reg);
    assign m_tuser  = m_status_reg;

endmodule

// ----- hdl/mqsb_checker.sv -----
// Port-level checker for the multi-queue shared buffer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mqsb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [mqsb_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [mqsb_pkg::OP_W-1:0]      s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [mqsb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mqsb_pkg::STATUS_W-1:0]  m_tuser
);

    logic in_acc;
    logic uflow;
    logic oflow;

    assign in_acc = s_tvalid && s_tready;
    assign uflow  = m_tvalid && (m_tuser == mqsb_pkg::STATUS_UNDERFLOW);
    // an overflow only comes from an enqueue
    assign oflow  = m_tvalid && (m_tuser == mqsb_pkg::STATUS_OVERFLOW);

    // one item at a time: no second item right behind an accepted one
    `MQ_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, in_acc, !s_tready)
    // every accepted item is followed by a valid result on m_tvalid
    `MQ_ASSERT_IMPL(a_result_follows, aclk, aresetn, in_acc, ##2 m_tvalid)
    `MQ_ASSERT_IMPL(a_underflow_word, aclk, aresetn, uflow, m_tdata == '1)
    `MQ_ASSERT_IMPL(a_overflow_word, aclk, aresetn, oflow, m_tdata == '0)
    `MQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser};

endmodule

bind multi_queue_shared_buffer_top mqsb_checker u_mqsb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
